@@ design/stb_pkg.sv @@
package stb_pkg;

    localparam int NUM_TIMERS_DEF = 8;
    localparam int MASK_W         = 8;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_SET   = 3'd1,
        OP_STOP  = 3'd2,
        OP_QUERY = 3'd3,
        OP_CLEAR = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_QCMP,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  timer_index;
        logic [31:0] duration_ms;
        logic        has_callback;
    } cmd_t;

    typedef struct packed {
        logic              status_error;
        logic              timed_out;
        logic [MASK_W-1:0] fired_mask;
        logic [31:0]       tick_count;
    } rsp_t;

endpackage

@@ design/software_timer_bank_core.sv @@
// Bank of NUM_TIMERS one-shot timers driven by tick, set, stop, query and
// clear-all commands. A command is taken when start is high and busy is low;
// its one result appears on result for the single cycle that done is high,
// and must be captured then. Counts and targets live in two small memories
// that share one registered read port, each with its own write port, and a
// single compare/increment unit walks the timers one per cycle. An enabled
// tick walks every timer, a query reads and then compares, others end in EXEC.
module software_timer_bank_core #(
    parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    input  logic         start,
    input  stb_pkg::cmd_t cmd,
    output logic         busy,
    output logic         done,
    output stb_pkg::rsp_t result
);
    import stb_pkg::*;

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);

    state_t state_reg, state_next;
    cmd_t   cmd_reg;
    logic   enabled_reg;
    logic [31:0] tick_reg, tick_next;

    logic [NUM_TIMERS-1:0] run_reg, run_next;
    logic [NUM_TIMERS-1:0] ntf_reg, ntf_next;
    logic [NUM_TIMERS-1:0] want_reg, want_next;
    logic [NUM_TIMERS-1:0] cvld_reg, cvld_next;
    logic [NUM_TIMERS-1:0] tvld_reg, tvld_next;

    logic [CW-1:0]     walk_reg, walk_next;
    logic              p_vld_reg, p_vld_next;
    logic [IW-1:0]     p_idx_reg, p_idx_next;
    logic [MASK_W-1:0] mask_reg, mask_next;

    logic done_reg, done_next;
    rsp_t rsp_reg, rsp_next;

    logic [31:0] cnt_mem [NUM_TIMERS];
    logic [31:0] tgt_mem [NUM_TIMERS];
    logic [31:0] cnt_rd_reg, tgt_rd_reg;
    logic        rd_en, cnt_we, tgt_we;
    logic [IW-1:0] rd_addr;

    logic [IW-1:0] cmd_idx, unit_idx;
    logic          idx_ok;
    logic [31:0]   cur_cnt, cur_tgt, cnt_inc;
    logic          cnt_lt;
    logic [7:0]    p_ext;

    assign cmd_idx = cmd_reg.timer_index[IW-1:0];
    assign idx_ok  = cmd_reg.timer_index < 8'(NUM_TIMERS);
    assign p_ext   = 8'(p_idx_reg);

    // shared compare/increment unit; entries never written read as zero
    assign unit_idx = (state_reg == ST_WALK) ? p_idx_reg : cmd_idx;
    assign cur_cnt  = cvld_reg[unit_idx] ? cnt_rd_reg : 32'd0;
    assign cur_tgt  = tvld_reg[unit_idx] ? tgt_rd_reg : 32'd0;
    assign cnt_lt   = cur_cnt < cur_tgt;
    assign cnt_inc  = cur_cnt + 32'd1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (op_t'(cmd_reg.op) == OP_TICK && enabled_reg)
                    state_next = ST_WALK;
                else if (op_t'(cmd_reg.op) == OP_QUERY)
                    state_next = ST_QCMP;
                else
                    state_next = ST_IDLE;
            end
            ST_QCMP:
                state_next = ST_IDLE;
            ST_WALK:
            begin
                if (walk_reg == CW'(NUM_TIMERS) && p_vld_reg)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        tick_next  = tick_reg;
        run_next   = run_reg;
        ntf_next   = ntf_reg;
        want_next  = want_reg;
        cvld_next  = cvld_reg;
        tvld_next  = tvld_reg;
        walk_next  = walk_reg;
        p_vld_next = 1'b0;
        p_idx_next = p_idx_reg;
        mask_next  = mask_reg;
        rd_en      = 1'b0;
        rd_addr    = cmd_idx;
        cnt_we     = 1'b0;
        tgt_we     = 1'b0;
        done_next  = 1'b0;
        rsp_next   = '0;
        rsp_next.tick_count = tick_reg;
        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_EXEC:
            begin
                done_next = 1'b1;
                case (op_t'(cmd_reg.op))
                    OP_TICK:
                    begin
                        tick_next = tick_reg + 32'd1;
                        rsp_next.tick_count = tick_next;
                        if (enabled_reg)
                        begin
                            done_next = 1'b0;
                            walk_next = '0;
                            mask_next = '0;
                        end
                    end
                    OP_SET:
                    begin
                        if (!idx_ok)
                            rsp_next.status_error = 1'b1;
                        else if (!run_reg[cmd_idx])
                        begin
                            run_next[cmd_idx]  = 1'b1;
                            ntf_next[cmd_idx]  = 1'b0;
                            want_next[cmd_idx] = cmd_reg.has_callback;
                            cvld_next[cmd_idx] = 1'b0;
                            tvld_next[cmd_idx] = 1'b1;
                            tgt_we             = 1'b1;
                        end
                    end
                    OP_STOP:
                    begin
                        if (!idx_ok)
                            rsp_next.status_error = 1'b1;
                        else
                        begin
                            run_next[cmd_idx]  = 1'b0;
                            cvld_next[cmd_idx] = 1'b0;
                        end
                    end
                    OP_QUERY:
                    begin
                        done_next = 1'b0;
                        rd_en     = 1'b1;
                    end
                    OP_CLEAR:
                    begin
                        run_next  = '0;
                        ntf_next  = '0;
                        want_next = '0;
                        cvld_next = '0;
                        tvld_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_QCMP:
            begin
                done_next          = 1'b1;
                rsp_next.timed_out = idx_ok && !cnt_lt;
            end
            ST_WALK:
            begin
                // read the next timer while the previous one is updated
                if (walk_reg < CW'(NUM_TIMERS))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = walk_reg[IW-1:0];
                    p_vld_next = 1'b1;
                    p_idx_next = walk_reg[IW-1:0];
                    walk_next  = walk_reg + CW'(1);
                end
                if (p_vld_reg && run_reg[p_idx_reg])
                begin
                    if (cnt_lt)
                    begin
                        cnt_we              = 1'b1;
                        cvld_next[p_idx_reg] = 1'b1;
                    end
                    else if (!ntf_reg[p_idx_reg] && want_reg[p_idx_reg])
                    begin
                        ntf_next[p_idx_reg] = 1'b1;
                        if (p_ext < 8'(MASK_W))
                            mask_next[p_ext[2:0]] = 1'b1;
                    end
                end
                if (walk_reg == CW'(NUM_TIMERS) && p_vld_reg)
                begin
                    done_next           = 1'b1;
                    rsp_next.fired_mask = mask_next;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            enabled_reg <= 1'b0;
            tick_reg    <= '0;
            run_reg     <= '0;
            ntf_reg     <= '0;
            want_reg    <= '0;
            cvld_reg    <= '0;
            tvld_reg    <= '0;
            walk_reg    <= '0;
            p_vld_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                enabled_reg <= cfg_wdata;
            tick_reg  <= tick_next;
            run_reg   <= run_next;
            ntf_reg   <= ntf_next;
            want_reg  <= want_next;
            cvld_reg  <= cvld_next;
            tvld_reg  <= tvld_next;
            walk_reg  <= walk_next;
            p_vld_reg <= p_vld_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            cmd_reg <= cmd;
        p_idx_reg <= p_idx_next;
        mask_reg  <= mask_next;
        rsp_reg   <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[p_idx_reg] <= cnt_inc;
        if (tgt_we)
            tgt_mem[cmd_idx] <= cmd_reg.duration_ms;
        if (rd_en)
        begin
            cnt_rd_reg <= cnt_mem[rd_addr];
            tgt_rd_reg <= tgt_mem[rd_addr];
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a command in flight");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not start work");

    a_mask_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.fired_mask != '0 |-> cmd_reg.op == OP_TICK)
        else $error("fired mask on a non-tick item");

    a_err_tmo_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.status_error && result.timed_out))
        else $error("error and timeout reported together");

endmodule
